/* hw/rtl/slu_pkg.sv */
// ----------------------------------------------------------------------------
// slu_pkg: shared types and constants for the string literal unescaper
// Decoder modes, result kinds, character codes and the record that the
// front end hands to the output sequencer.
// ----------------------------------------------------------------------------
package slu_pkg;

	localparam int CpW  = 21;
	localparam int ValW = 32;

	typedef enum logic [3:0] {
		M_START  = 4'd0,
		M_BODY   = 4'd1,
		M_ESC    = 4'd2,
		M_HEX    = 4'd3,
		M_DEC    = 4'd4,
		M_OCT    = 4'd5,
		M_UNI    = 4'd6,
		M_CLOSED = 4'd7,
		M_TRAIL  = 4'd8
	} mode_t;

	typedef enum logic [1:0] {
		K_CHAR   = 2'd0,
		K_OK     = 2'd1,
		K_TRAIL  = 2'd2,
		K_HEXEXP = 2'd3
	} kind_t;

	localparam logic [CpW-1:0] CH_QUOTE  = 21'h22;
	localparam logic [CpW-1:0] CH_BSLASH = 21'h5C;
	localparam logic [CpW-1:0] CH_0      = 21'h30;
	localparam logic [CpW-1:0] CH_7      = 21'h37;
	localparam logic [CpW-1:0] CH_9      = 21'h39;
	localparam logic [CpW-1:0] CH_UA     = 21'h41;
	localparam logic [CpW-1:0] CH_UD     = 21'h44;
	localparam logic [CpW-1:0] CH_UF     = 21'h46;
	localparam logic [CpW-1:0] CH_UU     = 21'h55;
	localparam logic [CpW-1:0] CH_UX     = 21'h58;
	localparam logic [CpW-1:0] CH_LA     = 21'h61;
	localparam logic [CpW-1:0] CH_LB     = 21'h62;
	localparam logic [CpW-1:0] CH_LD     = 21'h64;
	localparam logic [CpW-1:0] CH_LF     = 21'h66;
	localparam logic [CpW-1:0] CH_LN     = 21'h6E;
	localparam logic [CpW-1:0] CH_LR     = 21'h72;
	localparam logic [CpW-1:0] CH_LT     = 21'h74;
	localparam logic [CpW-1:0] CH_LU     = 21'h75;
	localparam logic [CpW-1:0] CH_LV     = 21'h76;
	localparam logic [CpW-1:0] CH_LX     = 21'h78;

	localparam logic [3:0] UNI_SHORT = 4'd4;
	localparam logic [3:0] UNI_LONG  = 4'd8;

	// Up to two decoded characters and one end word per input character.
	typedef struct packed {
		logic            c1_vld;
		logic [ValW-1:0] c1_val;
		logic            c2_vld;
		logic [ValW-1:0] c2_val;
		logic            end_vld;
		kind_t           end_kind;
	} rec_t;

	// Returns {is_hex, digit}.
	function automatic logic [4:0] hex_digit(input logic [CpW-1:0] c);
		logic [CpW-1:0] t;
		logic [4:0]     r;
		t = '0;
		r = '0;
		if (c >= CH_0 && c <= CH_9) begin
			t = c - CH_0;
			r = {1'b1, t[3:0]};
		end else if (c >= CH_LA && c <= CH_LF) begin
			t = c - CH_LA + 21'd10;
			r = {1'b1, t[3:0]};
		end else if (c >= CH_UA && c <= CH_UF) begin
			t = c - CH_UA + 21'd10;
			r = {1'b1, t[3:0]};
		end
		return r;
	endfunction

endpackage

/* hw/rtl/slu_front.sv */
// ----------------------------------------------------------------------------
// slu_front: character classifier and escape state machine
// Takes one character per cycle while q_full is low, advances the decoder
// state and builds the record of result words that the character causes.
// ----------------------------------------------------------------------------
module slu_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [slu_pkg::CpW-1:0]    code_point,
	input  logic                       is_last,
	input  logic                       q_full,
	output logic                       push,
	output slu_pkg::rec_t              rec
);
	import slu_pkg::*;

	mode_t            mode_q, mode_n;
	logic [ValW-1:0]  acc_q, acc_n;
	logic [3:0]       dl_q, dl_n;

	logic             s1v, s2v, fv, do_plain;
	logic [ValW-1:0]  s1, s2, f;
	logic [4:0]       hx;
	logic [CpW-1:0]   dd;
	logic [3:0]       dl_dec;
	logic [ValW-1:0]  acc_upd;
	kind_t            end_kind;
	logic             take;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign hx       = hex_digit(code_point);
	assign dd       = code_point - CH_0;
	assign dl_dec   = (dl_q != 4'd0) ? dl_q - 4'd1 : 4'd0;

	always_comb begin
		mode_n   = mode_q;
		acc_n    = acc_q;
		dl_n     = dl_q;
		s1v      = 1'b0;
		s1       = '0;
		s2v      = 1'b0;
		s2       = '0;
		fv       = 1'b0;
		f        = '0;
		do_plain = 1'b0;
		end_kind = K_OK;
		acc_upd  = '0;

		unique case (mode_q)
			M_START: begin
				if (code_point == CH_QUOTE) begin
					mode_n = M_BODY;
				end else begin
					do_plain = 1'b1;
				end
			end
			M_ESC: begin
				acc_n = '0;
				if (code_point == CH_LX || code_point == CH_UX) begin
					mode_n = M_HEX;
				end else if (code_point == CH_LD || code_point == CH_UD) begin
					mode_n = M_DEC;
				end else if (code_point >= CH_0 && code_point <= CH_7) begin
					acc_n  = ValW'(code_point[2:0]);
					mode_n = M_OCT;
				end else if (code_point == CH_LU) begin
					dl_n   = UNI_SHORT;
					mode_n = M_UNI;
				end else if (code_point == CH_UU) begin
					dl_n   = UNI_LONG;
					mode_n = M_UNI;
				end else begin
					mode_n = M_BODY;
					s1v    = 1'b1;
					if (code_point == CH_LA) s1 = 32'd7;
					else if (code_point == CH_LB) s1 = 32'd8;
					else if (code_point == CH_LF) s1 = 32'd12;
					else if (code_point == CH_LN) s1 = 32'd10;
					else if (code_point == CH_LR) s1 = 32'd13;
					else if (code_point == CH_LT) s1 = 32'd9;
					else if (code_point == CH_LV) s1 = 32'd11;
					else s1 = ValW'(code_point);
				end
			end
			M_HEX: begin
				if (hx[4]) begin
					acc_n = {acc_q[ValW-5:0], hx[3:0]};
				end else begin
					s1v = 1'b1; s1 = acc_q; acc_n = '0; do_plain = 1'b1;
				end
			end
			M_DEC: begin
				if (code_point >= CH_0 && code_point <= CH_9) begin
					acc_n = {acc_q[ValW-4:0], 3'b000} + {acc_q[ValW-2:0], 1'b0}
						+ ValW'(dd[3:0]);
				end else begin
					s1v = 1'b1; s1 = acc_q; acc_n = '0; do_plain = 1'b1;
				end
			end
			M_OCT: begin
				if (code_point >= CH_0 && code_point <= CH_7) begin
					acc_n = {acc_q[ValW-4:0], code_point[2:0]};
				end else begin
					s1v = 1'b1; s1 = acc_q; acc_n = '0; do_plain = 1'b1;
				end
			end
			M_UNI: begin
				// Characters that are not hex digits still count toward the length.
				acc_upd = hx[4] ? {acc_q[ValW-5:0], hx[3:0]} : acc_q;
				acc_n   = acc_upd;
				dl_n    = dl_dec;
				if (dl_dec == 4'd0) begin
					s1v    = 1'b1;
					s1     = acc_upd;
					acc_n  = '0;
					mode_n = M_BODY;
				end
			end
			M_CLOSED, M_TRAIL: begin
				mode_n = M_TRAIL;
			end
			default: begin
				do_plain = 1'b1;
			end
		endcase

		if (do_plain) begin
			if (code_point == CH_QUOTE) begin
				mode_n = M_CLOSED;
			end else if (code_point == CH_BSLASH) begin
				mode_n = M_ESC;
			end else begin
				mode_n = M_BODY;
				if (s1v) begin
					s2v = 1'b1; s2 = ValW'(code_point);
				end else begin
					s1v = 1'b1; s1 = ValW'(code_point);
				end
			end
		end

		if (is_last) begin
			unique case (mode_n)
				M_ESC: begin
					fv = 1'b1;
				end
				M_HEX, M_DEC, M_OCT: begin
					fv = 1'b1; f = acc_n;
				end
				M_UNI:   end_kind = K_HEXEXP;
				M_TRAIL: end_kind = K_TRAIL;
				default: end_kind = K_OK;
			endcase
		end

		// Pack the step's characters and the end-of-token flush in order.
		rec.c1_vld   = s1v || fv;
		rec.c1_val   = s1v ? s1 : f;
		rec.c2_vld   = s1v && (s2v || fv);
		rec.c2_val   = s2v ? s2 : f;
		rec.end_vld  = is_last;
		rec.end_kind = end_kind;
	end

	assign push = take && (rec.c1_vld || rec.end_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_START;
			acc_q  <= '0;
			dl_q   <= '0;
		end else if (take) begin
			if (is_last) begin
				mode_q <= M_START;
				acc_q  <= '0;
				dl_q   <= '0;
			end else begin
				mode_q <= mode_n;
				acc_q  <= acc_n;
				dl_q   <= dl_n;
			end
		end
	end

endmodule

/* hw/rtl/slu_fifo.sv */
// ----------------------------------------------------------------------------
// slu_fifo: record queue between front end and output sequencer
// A small register queue that lets either side stall on its own.
// DEPTH must be at least 2.
// ----------------------------------------------------------------------------
module slu_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  slu_pkg::rec_t wdata,
	input  logic          pop,
	output slu_pkg::rec_t rdata,
	output logic          full,
	output logic          empty
);
	import slu_pkg::*;

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	rec_t              mem_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   cnt_q;
	logic              do_push, do_pop;

	assign full    = (cnt_q == CntW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/slu_back.sv */
// ----------------------------------------------------------------------------
// slu_back: output sequencer
// Unpacks each queued record into one to three result words and drives the
// output register, one word per cycle while out_ready allows.
// ----------------------------------------------------------------------------
module slu_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  slu_pkg::rec_t               q_rec,
	input  logic                        q_empty,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  kind,
	output logic [slu_pkg::ValW-1:0]    value,
	output logic                        final_result
);
	import slu_pkg::*;

	// Pending words of the current record: bit 0 first char, bit 1 second, bit 2 end.
	logic [2:0]       pend_q, pend_after, low_bit;
	logic [ValW-1:0]  c1_q, c2_q;
	kind_t            end_kind_q;

	logic             out_valid_q;
	kind_t            kind_q;
	logic [ValW-1:0]  value_q;
	logic             final_q;
	logic             out_free, emit;

	assign out_free   = !out_valid_q || out_ready;
	assign emit       = out_free && (pend_q != 3'b000);
	assign low_bit    = pend_q & (~pend_q + 3'd1);
	assign pend_after = emit ? (pend_q & ~low_bit) : pend_q;
	assign pop        = !q_empty && (pend_after == 3'b000);

	always_ff @(posedge clk) begin
		if (pop) begin
			c1_q       <= q_rec.c1_val;
			c2_q       <= q_rec.c2_val;
			end_kind_q <= q_rec.end_kind;
		end
		if (emit) begin
			if (pend_q[0]) begin
				kind_q  <= K_CHAR;
				value_q <= c1_q;
				final_q <= 1'b0;
			end else if (pend_q[1]) begin
				kind_q  <= K_CHAR;
				value_q <= c2_q;
				final_q <= 1'b0;
			end else begin
				kind_q  <= end_kind_q;
				value_q <= '0;
				final_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= pop ? {q_rec.end_vld, q_rec.c2_vld, q_rec.c1_vld} : pend_after;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign value        = value_q;
	assign final_result = final_q;

endmodule

/* hw/rtl/string_literal_unescape.sv */
// ----------------------------------------------------------------------------
// string_literal_unescape: quoted literal escape decoder
// Decodes the characters of a quoted literal token into code points and
// reports the token's end status.
//
//   channel  handshake              words
//   in       in_valid / in_ready    code_point, is_last
//   out      out_valid / out_ready  kind, value, final_result
//
// One character is accepted per cycle while the record queue has room.
// The output register sends one result word per cycle when out_ready allows,
// so a character that yields two or three words holds the output side until
// all are sent. Words pass through the record queue, then the output register.
// Reset returns the decoder to the start of a token and empties the queue.
// ----------------------------------------------------------------------------
module string_literal_unescape #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [slu_pkg::CpW-1:0]     code_point,
	input  logic                        is_last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  kind,
	output logic [slu_pkg::ValW-1:0]    value,
	output logic                        final_result
);
	import slu_pkg::*;

	rec_t  push_rec, head_rec;
	logic  push, pop, q_full, q_empty;

	slu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code_point (code_point),
		.is_last    (is_last),
		.q_full     (q_full),
		.push       (push),
		.rec        (push_rec)
	);

	slu_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_rec),
		.pop    (pop),
		.rdata  (head_rec),
		.full   (q_full),
		.empty  (q_empty)
	);

	slu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_rec        (head_rec),
		.q_empty      (q_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.value        (value),
		.final_result (final_result)
	);

endmodule
